/* sv/nearest_polyline_segment_core_assert.svh */
// Assertion macros shared by the nearest polyline segment RTL.
`ifndef NEAREST_POLYLINE_SEGMENT_CORE_ASSERT_SVH
`define NEAREST_POLYLINE_SEGMENT_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define NPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/nps_pkg.sv */
// Types and constants of the nearest polyline segment block.
package nps_pkg;

    localparam int COORD_W              = 16;
    localparam int DIFF_W               = 17;
    localparam int MUL_W                = 18;
    localparam int PROD_W               = 2 * MUL_W;
    localparam int ACC_W                = 69;
    localparam int CR_W                 = 34;
    localparam int HALF_W               = 17;
    localparam int DIST_W               = 34;
    localparam int DOT_W                = 35;
    localparam int IDX_W                = 11;
    localparam int IDX_EXT_W            = 17;
    localparam int OUT_DIST_W           = 33;
    localparam int DIV_STEPS            = 34;
    localparam int DIV_CNT_W            = 6;
    localparam int DEFAULT_MAX_VERTICES = 1024;

    typedef enum logic [3:0] {
        S_IDLE,
        S_END,
        S_DIFF,
        S_MUL,
        S_ACC,
        S_SEL,
        S_ABS,
        S_DLOAD,
        S_DIV,
        S_CMP,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_WXVX,
        OP_WYVY,
        OP_VXVX,
        OP_VYVY,
        OP_WXWX,
        OP_WYWY,
        OP_EXEX,
        OP_EYEY,
        OP_WXVY,
        OP_WYVX,
        OP_C0C0,
        OP_C0C1,
        OP_C1C1
    } t_op;

    typedef enum logic [1:0] {
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_mode;

endpackage

/* sv/nearest_polyline_segment_core.sv */
// Nearest polyline segment to a query point, by squared distance.
//
//  Channel  Direction  Signals                                         Handshake
//  input    in         i_vertex_x/y, i_query_x/y, i_closed_flag,       i_valid / o_stall
//                      i_last_vertex
//  output   out        o_found, o_segment_index, o_min_distance_sq     o_valid / i_stall
//
// The first request of a run loads the query and first vertex; later vertices, up to
// MAX_VERTICES in all, are scored, with a division when the nearest point is inside.
// The pace is set by the shared 18x18 multiplier and the 34-step restoring divider.
// A last vertex of a closed run also scores the closing segment before the result is shown.
// Reset is synchronous and active low and starts a new run; there is no clearing pass.
// The result stays on the output until taken, and no request is taken while it waits.
module nearest_polyline_segment_core
    import nps_pkg::*;
#(
    parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_W-1:0]    i_vertex_x,
    input  logic signed [COORD_W-1:0]    i_vertex_y,
    input  logic signed [COORD_W-1:0]    i_query_x,
    input  logic signed [COORD_W-1:0]    i_query_y,
    input  logic                         i_closed_flag,
    input  logic                         i_last_vertex,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_found,
    output logic        [IDX_W-1:0]      o_segment_index,
    output logic        [OUT_DIST_W-1:0] o_min_distance_sq
);

    `include "nearest_polyline_segment_core_assert.svh"

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    t_state r_state, n_state;
    t_op    r_op;

    logic [CNT_W-1:0]            r_count;
    logic signed [COORD_W-1:0]   r_prev_x, r_prev_y, r_first_x, r_first_y;
    logic signed [COORD_W-1:0]   r_qx, r_qy, r_bx, r_by;
    logic                        r_held_closed, r_last, r_closing;
    logic signed [DIFF_W-1:0]    r_vx, r_vy, r_wx, r_wy, r_ex, r_ey;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [DOT_W-1:0]     r_dp1;
    logic [DIST_W-1:0]           r_dp2;
    logic [CR_W-1:0]             r_c;
    logic [DIST_W-1:0]           r_rem;
    logic [DIST_W-1:0]           r_num;
    logic [DIV_CNT_W-1:0]        r_div_cnt;
    logic [DIST_W-1:0]           r_dist;
    logic [DIST_W-1:0]           r_best;
    logic [CNT_W-1:0]            r_best_idx;
    logic                        r_have_best;

    logic                        w_accept, w_out_take;
    logic                        w_count_zero, w_count_room;
    logic signed [MUL_W-1:0]     w_ma, w_mb;
    logic signed [PROD_W-1:0]    w_prod;
    t_acc_mode                   w_mode;
    logic [5:0]                  w_shift;
    logic signed [ACC_W-1:0]     w_term, n_acc, w_abs;
    logic [DIST_W:0]             w_trial, w_trial_rem;
    logic                        w_ge;
    logic                        w_better;
    logic [IDX_EXT_W-1:0]        w_best_idx_ext;

    assign w_accept     = i_valid && !o_stall;
    assign w_out_take   = o_valid && !i_stall;
    assign w_count_zero = (r_count == '0);
    assign w_count_room = (r_count < CNT_W'(MAX_VERTICES));

    // Operand selection for the shared multiplier.
    always_comb begin
        w_ma    = {r_wx[DIFF_W-1], r_wx};
        w_mb    = {r_vx[DIFF_W-1], r_vx};
        w_mode  = ACC_LOAD;
        w_shift = 6'd0;
        unique case (r_op)
            OP_WXVX: begin
                w_ma = {r_wx[DIFF_W-1], r_wx};
                w_mb = {r_vx[DIFF_W-1], r_vx};
            end
            OP_WYVY: begin
                w_ma   = {r_wy[DIFF_W-1], r_wy};
                w_mb   = {r_vy[DIFF_W-1], r_vy};
                w_mode = ACC_ADD;
            end
            OP_VXVX: begin
                w_ma = {r_vx[DIFF_W-1], r_vx};
                w_mb = {r_vx[DIFF_W-1], r_vx};
            end
            OP_VYVY: begin
                w_ma   = {r_vy[DIFF_W-1], r_vy};
                w_mb   = {r_vy[DIFF_W-1], r_vy};
                w_mode = ACC_ADD;
            end
            OP_WXWX: begin
                w_ma = {r_wx[DIFF_W-1], r_wx};
                w_mb = {r_wx[DIFF_W-1], r_wx};
            end
            OP_WYWY: begin
                w_ma   = {r_wy[DIFF_W-1], r_wy};
                w_mb   = {r_wy[DIFF_W-1], r_wy};
                w_mode = ACC_ADD;
            end
            OP_EXEX: begin
                w_ma = {r_ex[DIFF_W-1], r_ex};
                w_mb = {r_ex[DIFF_W-1], r_ex};
            end
            OP_EYEY: begin
                w_ma   = {r_ey[DIFF_W-1], r_ey};
                w_mb   = {r_ey[DIFF_W-1], r_ey};
                w_mode = ACC_ADD;
            end
            OP_WXVY: begin
                w_ma = {r_wx[DIFF_W-1], r_wx};
                w_mb = {r_vy[DIFF_W-1], r_vy};
            end
            OP_WYVX: begin
                w_ma   = {r_wy[DIFF_W-1], r_wy};
                w_mb   = {r_vx[DIFF_W-1], r_vx};
                w_mode = ACC_SUB;
            end
            OP_C0C0: begin
                w_ma = {1'b0, r_c[HALF_W-1:0]};
                w_mb = {1'b0, r_c[HALF_W-1:0]};
            end
            OP_C0C1: begin
                w_ma    = {1'b0, r_c[HALF_W-1:0]};
                w_mb    = {1'b0, r_c[CR_W-1:HALF_W]};
                w_mode  = ACC_ADD;
                w_shift = 6'(HALF_W + 1);
            end
            OP_C1C1: begin
                w_ma    = {1'b0, r_c[CR_W-1:HALF_W]};
                w_mb    = {1'b0, r_c[CR_W-1:HALF_W]};
                w_mode  = ACC_ADD;
                w_shift = 6'(2 * HALF_W);
            end
            default: begin
                w_ma = {r_wx[DIFF_W-1], r_wx};
                w_mb = {r_vx[DIFF_W-1], r_vx};
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_term = ACC_W'(r_prod) <<< w_shift;

    always_comb begin
        unique case (w_mode)
            ACC_LOAD: n_acc = w_term;
            ACC_ADD:  n_acc = r_acc + w_term;
            ACC_SUB:  n_acc = r_acc - w_term;
            default:  n_acc = w_term;
        endcase
    end

    assign w_abs       = r_acc[ACC_W-1] ? -r_acc : r_acc;
    assign w_trial     = {r_rem, r_num[DIST_W-1]};
    assign w_ge        = (w_trial >= {1'b0, r_dp2});
    assign w_trial_rem = w_ge ? (w_trial - {1'b0, r_dp2}) : w_trial;
    assign w_better    = !r_have_best || (r_dist < r_best);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_count_zero) begin
                        n_state = i_last_vertex ? S_END : S_IDLE;
                    end else if (w_count_room) begin
                        n_state = S_DIFF;
                    end else begin
                        n_state = i_last_vertex ? S_END : S_IDLE;
                    end
                end
            end
            S_END:   n_state = r_held_closed ? S_DIFF : S_OUT;
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC: begin
                unique case (r_op) inside
                    OP_VYVY:                          n_state = S_SEL;
                    OP_WYWY, OP_EYEY:                 n_state = S_CMP;
                    OP_WYVX:                          n_state = S_ABS;
                    OP_C1C1:                          n_state = S_DLOAD;
                    default:                          n_state = S_MUL;
                endcase
            end
            S_SEL:   n_state = S_MUL;
            S_ABS:   n_state = S_MUL;
            S_DLOAD: n_state = S_DIV;
            S_DIV: begin
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_closing) begin
                    n_state = S_OUT;
                end else if (r_last) begin
                    n_state = S_END;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (w_out_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_stall = (r_state != S_IDLE);
        o_valid = (r_state == S_OUT);
    end

    assign w_best_idx_ext    = IDX_EXT_W'(r_best_idx);
    assign o_found           = r_have_best;
    assign o_segment_index   = r_have_best ? w_best_idx_ext[IDX_W-1:0] : '0;
    assign o_min_distance_sq = r_have_best ? r_best[OUT_DIST_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Run bookkeeping and best segment.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_have_best   <= 1'b0;
            r_best        <= '0;
            r_best_idx    <= '0;
            r_held_closed <= 1'b0;
            r_last        <= 1'b0;
            r_closing     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_last    <= i_last_vertex;
                        r_closing <= 1'b0;
                        if (w_count_zero) begin
                            r_qx          <= i_query_x;
                            r_qy          <= i_query_y;
                            r_held_closed <= i_closed_flag;
                            r_first_x     <= i_vertex_x;
                            r_first_y     <= i_vertex_y;
                            r_prev_x      <= i_vertex_x;
                            r_prev_y      <= i_vertex_y;
                            r_have_best   <= 1'b0;
                            r_best        <= '0;
                            r_best_idx    <= '0;
                            r_count       <= CNT_W'(1);
                        end else if (w_count_room) begin
                            r_bx <= i_vertex_x;
                            r_by <= i_vertex_y;
                        end
                    end
                end
                S_END: begin
                    r_bx      <= r_first_x;
                    r_by      <= r_first_y;
                    r_closing <= 1'b1;
                end
                S_CMP: begin
                    if (w_better) begin
                        r_best      <= r_dist;
                        r_best_idx  <= r_count;
                        r_have_best <= 1'b1;
                    end
                    if (!r_closing) begin
                        r_prev_x <= r_bx;
                        r_prev_y <= r_by;
                        r_count  <= r_count + CNT_W'(1);
                    end
                end
                S_OUT: begin
                    if (w_out_take) begin
                        r_count     <= '0;
                        r_have_best <= 1'b0;
                        r_best      <= '0;
                        r_best_idx  <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Shared multiplier, accumulator and divider datapath.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_DIFF: begin
                r_vx <= DIFF_W'(r_bx) - DIFF_W'(r_prev_x);
                r_vy <= DIFF_W'(r_by) - DIFF_W'(r_prev_y);
                r_wx <= DIFF_W'(r_qx) - DIFF_W'(r_prev_x);
                r_wy <= DIFF_W'(r_qy) - DIFF_W'(r_prev_y);
                r_ex <= DIFF_W'(r_qx) - DIFF_W'(r_bx);
                r_ey <= DIFF_W'(r_qy) - DIFF_W'(r_by);
                r_op <= OP_WXVX;
            end
            S_MUL: begin
                r_prod <= w_prod;
            end
            S_ACC: begin
                r_acc <= n_acc;
                unique case (r_op) inside
                    OP_WXVX: r_op <= OP_WYVY;
                    OP_WYVY: begin
                        r_dp1 <= n_acc[DOT_W-1:0];
                        r_op  <= OP_VXVX;
                    end
                    OP_VXVX: r_op <= OP_VYVY;
                    OP_VYVY: r_dp2 <= n_acc[DIST_W-1:0];
                    OP_WXWX: r_op <= OP_WYWY;
                    OP_EXEX: r_op <= OP_EYEY;
                    OP_WYWY, OP_EYEY: r_dist <= n_acc[DIST_W-1:0];
                    OP_WXVY: r_op <= OP_WYVX;
                    OP_C0C0: r_op <= OP_C0C1;
                    OP_C0C1: r_op <= OP_C1C1;
                    default: begin
                    end
                endcase
            end
            S_SEL: begin
                if (r_dp1 <= 0) begin
                    r_op <= OP_WXWX;
                end else if ($signed({1'b0, r_dp2}) <= r_dp1) begin
                    r_op <= OP_EXEX;
                end else begin
                    r_op <= OP_WXVY;
                end
            end
            S_ABS: begin
                r_c  <= w_abs[CR_W-1:0];
                r_op <= OP_C0C0;
            end
            S_DLOAD: begin
                r_rem     <= r_acc[2*DIST_W-1:DIST_W];
                r_num     <= r_acc[DIST_W-1:0];
                r_div_cnt <= '0;
            end
            S_DIV: begin
                r_rem     <= w_trial_rem[DIST_W-1:0];
                r_num     <= {r_num[DIST_W-2:0], w_ge};
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_dist <= {r_num[DIST_W-2:0], w_ge};
                end
            end
            default: begin
            end
        endcase
    end

    `NPS_ASSERT_SAME(a_out_blocks_in, i_clk, i_rst_n, o_valid, o_stall,
        "input taken while a result waits")
    `NPS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(MAX_VERTICES), "vertex count above its limit")
    `NPS_ASSERT_SAME(a_div_rem_bound, i_clk, i_rst_n, r_state == S_DIV,
        r_rem < r_dp2, "divider remainder not below the divisor")
    `NPS_ASSERT_SAME(a_best_idx_set, i_clk, i_rst_n, r_have_best,
        r_best_idx != '0, "best segment held without an index")
    `NPS_ASSERT_NEXT(a_cmp_leaves, i_clk, i_rst_n, r_state == S_CMP,
        r_state == S_IDLE || r_state == S_END || r_state == S_OUT,
        "compare step did not finish the segment")

endmodule
